/* src/rfip_pkg.sv */
// ----------------------------------------------------------------------------
// rfip_pkg: shared definitions for the ring FIFO with indexed peek
// Operation codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfip_pkg;

   typedef logic [1:0] op_type;
   typedef logic [3:0] csr_index_type;

   localparam op_type OP_PUSH  = 2'd0;
   localparam op_type OP_POP   = 2'd1;
   localparam op_type OP_READ  = 2'd2;
   localparam op_type OP_CLEAR = 2'd3;

   localparam csr_index_type CSR_QUEUE_SIZE    = 4'd0;
   localparam csr_index_type CSR_ELEMENT_BYTES = 4'd1;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int ELEM_BYTES_DEFAULT = 8;

   localparam logic [8:0] QUEUE_SIZE_RESET    = 9'd0;
   localparam logic [3:0] ELEMENT_BYTES_RESET = 4'd8;

endpackage

`default_nettype wire

/* src/ring_fifo_with_indexed_peek.sv */
// ----------------------------------------------------------------------------
// ring_fifo_with_indexed_peek: circular FIFO with push, pop, peek and clear
//
// Request channel (req_*): one operation per transfer. Push stores the low
// byte_count bytes of data_in (whole element for 0 or oversize), pop
// removes the oldest entry, read returns the entry peek_index places after
// the oldest, clear empties the ring. One slot stays free.
// Response channel (rsp_*): exactly one transfer per request, in order,
// carrying ok, data_out, stored_count and the empty and full flags as they
// stand after the operation.
// The response is registered at the request transfer and is valid in the
// cycle after; one request is taken every cycle while responses drain.
// Pointers update and the slot store is read at the request transfer edge.
// When rsp_stall is high the response register holds and req_stall rises
// until the response is taken.
// CSR channel (csr_*): queue_size (index 0) and element_bytes (index 1);
// csr_ready is always high and any write to them clears both pointers.
// Reset clears the pointers, sets queue_size 0 and element_bytes 8 and
// empties the response register; the slot store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_fifo_with_indexed_peek
   import rfip_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ELEM_BYTES = ELEM_BYTES_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire op_type        req_operation,
   input  wire logic [63:0]   req_data_in,
   input  wire logic [3:0]    req_byte_count,
   input  wire logic [7:0]    req_peek_index,

   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_ok,
   output logic [63:0]        rsp_data_out,
   output logic [7:0]         rsp_stored_count,
   output logic               rsp_is_empty,
   output logic               rsp_is_full,

   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = PW + 1;
   localparam int CW = (NW > 8) ? NW : 8;

   logic [8:0]            q_size_ff;
   logic [3:0]            e_bytes_ff;
   logic [PW-1:0]         wp_ff, wp_in;
   logic [PW-1:0]         rp_ff, rp_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  ok_ff, ok_in;
   logic [7:0]            count_ff, count_in;
   logic                  empty_ff, empty_in;
   logic                  full_ff, full_in;
   logic [ELEM_BYTES-1:0] dmask_ff, dmask_in;

   logic                  req_accept;
   logic                  csr_write;
   logic [NW-1:0]         ring_n;
   logic [3:0]            elem_n;
   logic [3:0]            push_n;
   logic [NW-1:0]         count_cur, count_nxt;
   logic                  full_cur;
   logic [PW-1:0]         wp_inc, rp_inc;
   logic [CW:0]           peek_sum;
   logic [PW-1:0]         peek_addr;
   logic [PW-1:0]         rd_addr;
   logic                  mem_we;
   logic [ELEM_BYTES-1:0] lane_we;
   logic [ELEM_BYTES-1:0] lane_mask;
   logic [ELEM_BYTES*8-1:0] rd_data;

   function automatic logic [NW-1:0] count_f(input logic [PW-1:0] w,
                                             input logic [PW-1:0] r,
                                             input logic [NW-1:0] nn);
      logic [NW-1:0] res;
      if (nn == '0) begin
         res = '0;
      end else if (w >= r) begin
         res = NW'(w) - NW'(r);
      end else begin
         res = NW'(w) + nn - NW'(r);
      end
      return res;
   endfunction

   function automatic logic full_f(input logic [PW-1:0] w,
                                   input logic [PW-1:0] r,
                                   input logic [NW-1:0] nn);
      logic [NW-1:0] lim;
      logic          res;
      lim = (r == '0) ? (nn - NW'(1)) : (NW'(r) - NW'(1));
      res = (nn != '0) && (NW'(w) == lim);
      return res;
   endfunction

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready &&
                       (csr_index == CSR_QUEUE_SIZE || csr_index == CSR_ELEMENT_BYTES);
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign ring_n = ({23'b0, q_size_ff} > 32'(DEPTH)) ? NW'(DEPTH) : NW'(q_size_ff);
   assign elem_n = (e_bytes_ff > 4'(ELEM_BYTES)) ? 4'(ELEM_BYTES) : e_bytes_ff;
   assign push_n = (req_byte_count == 4'd0 || req_byte_count > elem_n) ? elem_n
                                                                       : req_byte_count;

   assign count_cur = count_f(wp_ff, rp_ff, ring_n);
   assign full_cur  = full_f(wp_ff, rp_ff, ring_n);
   assign wp_inc    = ((NW'(wp_ff) + NW'(1)) >= ring_n) ? '0 : (wp_ff + PW'(1));
   assign rp_inc    = ((NW'(rp_ff) + NW'(1)) >= ring_n) ? '0 : (rp_ff + PW'(1));
   assign peek_sum  = (CW+1)'(rp_ff) + (CW+1)'(req_peek_index);
   assign peek_addr = (peek_sum >= (CW+1)'(ring_n)) ? PW'(peek_sum - (CW+1)'(ring_n))
                                                   : PW'(peek_sum);
   assign rd_addr   = (req_operation == OP_READ) ? peek_addr : rp_ff;

   always_comb begin
      for (int i = 0; i < ELEM_BYTES; i++) begin
         lane_we[i]   = 4'(i) < push_n;
         lane_mask[i] = 4'(i) < elem_n;
      end
   end

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      ok_in  = 1'b0;
      mem_we = 1'b0;
      dmask_in = '0;
      if (ring_n != '0) begin
         case (req_operation)
            OP_PUSH: begin
               if (!full_cur) begin
                  mem_we = 1'b1;
                  wp_in  = wp_inc;
                  ok_in  = 1'b1;
               end
            end
            OP_POP: begin
               if (wp_ff != rp_ff) begin
                  rp_in    = rp_inc;
                  ok_in    = 1'b1;
                  dmask_in = lane_mask;
               end
            end
            OP_READ: begin
               if (CW'(req_peek_index) < CW'(count_cur)) begin
                  ok_in    = 1'b1;
                  dmask_in = lane_mask;
               end
            end
            OP_CLEAR: begin
               wp_in = '0;
               rp_in = '0;
               ok_in = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
      count_nxt = count_f(wp_in, rp_in, ring_n);
      count_in  = 8'(count_nxt);
      empty_in  = (wp_in == rp_in);
      full_in   = full_f(wp_in, rp_in, ring_n);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_size_ff    <= QUEUE_SIZE_RESET;
         e_bytes_ff   <= ELEMENT_BYTES_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            if (csr_index == CSR_QUEUE_SIZE) begin
               q_size_ff <= csr_data[8:0];
            end else begin
               e_bytes_ff <= csr_data[3:0];
            end
            wp_ff <= '0;
            rp_ff <= '0;
         end else if (req_accept) begin
            wp_ff <= wp_in;
            rp_ff <= rp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ok_ff    <= ok_in;
         count_ff <= count_in;
         empty_ff <= empty_in;
         full_ff  <= full_in;
         dmask_ff <= dmask_in;
      end
   end

   for (genvar g = 0; g < ELEM_BYTES; g++) begin : g_lane
      logic [7:0] lane_mem [DEPTH];
      logic [7:0] lane_rd_ff;

      always_ff @(posedge clock) begin
         if (req_accept && mem_we && lane_we[g]) begin
            lane_mem[wp_ff] <= req_data_in[8*g +: 8];
         end
         if (req_accept) begin
            lane_rd_ff <= lane_mem[rd_addr];
         end
      end

      assign rd_data[8*g +: 8] = lane_rd_ff & {8{dmask_ff[g]}};
   end

   if (ELEM_BYTES < 8) begin : g_pad
      assign rsp_data_out = {{(64 - ELEM_BYTES*8){1'b0}}, rd_data};
   end else begin : g_full
      assign rsp_data_out = rd_data;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = ok_ff;
   assign rsp_stored_count = count_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;

endmodule

`default_nettype wire

/* verif/tb_ring_fifo_with_indexed_peek.sv */
// ----------------------------------------------------------------------------
// tb_ring_fifo_with_indexed_peek: self-checking bench for the ring FIFO
// A directed table covers the uninitialized ring, the single-slot ring,
// full and empty, partial pushes, oversized sizes and zero-byte elements.
// Random phases follow under several register settings and idle patterns.
// Responses are checked against a cycle-free ring shadow or a table result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ring_fifo_with_indexed_peek;
   import rfip_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam int LANES      = ELEM_BYTES_DEFAULT;
   localparam logic [63:0] ONES = {64{1'b1}};

   typedef struct packed {
      op_type      op;
      logic [63:0] data;
      logic [3:0]  count_bytes;
      logic [7:0]  peek;
   } fifo_request;

   typedef struct packed {
      logic        ok;
      logic [63:0] data;
      logic [7:0]  count;
      logic        empty;
      logic        full;
   } fifo_result;

   typedef struct {
      bit            is_reg;
      csr_index_type reg_idx;
      logic [31:0]   reg_val;
      fifo_request   rq;
      bit            typed;
      fifo_result    res;
   } plan_row;

   localparam fifo_result UNINIT_FAIL = {1'b0, 64'd0, 8'd0, 1'b1, 1'b0};

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   op_type        req_operation;
   logic [63:0]   req_data_in;
   logic [3:0]    req_byte_count;
   logic [7:0]    req_peek_index;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_ok;
   logic [63:0]   rsp_data_out;
   logic [7:0]    rsp_stored_count;
   logic          rsp_is_empty;
   logic          rsp_is_full;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [31:0]   csr_data;

   logic [63:0] shadow_slots [RING_DEPTH];
   logic [7:0]  shadow_written [RING_DEPTH];
   int          shadow_wp;
   int          shadow_rp;
   logic [8:0]  shadow_qs;
   logic [3:0]  shadow_eb;

   fifo_result  expected_responses [$];
   plan_row     plan [$];
   int          mismatch_count = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   int phase_qs [9] = '{3, 256, 2, 5, 0, 17, 1, 300, 9};
   int phase_eb [9] = '{8, 8, 1, 4, 8, 15, 2, 0, 7};

   ring_fifo_with_indexed_peek u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_data_in      (req_data_in),
      .req_byte_count   (req_byte_count),
      .req_peek_index   (req_peek_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_data_out     (rsp_data_out),
      .rsp_stored_count (rsp_stored_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int ring_slots();
      return (shadow_qs > RING_DEPTH) ? RING_DEPTH : int'(shadow_qs);
   endfunction

   function automatic int elem_len();
      return (shadow_eb > LANES) ? LANES : int'(shadow_eb);
   endfunction

   function automatic logic [63:0] lane_mask(int nbytes);
      if (nbytes >= 8) return ONES;
      return (64'd1 << (nbytes * 8)) - 64'd1;
   endfunction

   function automatic logic [7:0] byte_lanes(int nbytes);
      if (nbytes >= 8) return 8'hFF;
      return (8'd1 << nbytes) - 8'd1;
   endfunction

   function automatic int entry_count(int n);
      if (n == 0) return 0;
      if (shadow_wp >= shadow_rp) return shadow_wp - shadow_rp;
      return shadow_wp + n - shadow_rp;
   endfunction

   function automatic bit ring_full(int n);
      int limit;
      if (n == 0) return 1'b0;
      limit = (shadow_rp == 0) ? n - 1 : shadow_rp - 1;
      return shadow_wp == limit;
   endfunction

   task automatic apply_operation(input fifo_request rq, output fifo_result rs);
      int          n;
      int          eb;
      int          nb;
      int          p;
      logic [63:0] m;
      n  = ring_slots();
      eb = elem_len();
      rs = '0;
      if (n != 0) begin
         case (rq.op)
            OP_PUSH: begin
               if (!ring_full(n)) begin
                  nb = rq.count_bytes;
                  if (nb == 0 || nb > eb) nb = eb;
                  m = lane_mask(nb);
                  shadow_slots[shadow_wp] = (shadow_slots[shadow_wp] & ~m) | (rq.data & m);
                  shadow_written[shadow_wp] |= byte_lanes(nb);
                  shadow_wp = (shadow_wp + 1 >= n) ? 0 : shadow_wp + 1;
                  rs.ok = 1'b1;
               end
            end
            OP_POP: begin
               if (shadow_wp != shadow_rp) begin
                  rs.data = shadow_slots[shadow_rp] & lane_mask(eb);
                  shadow_rp = (shadow_rp + 1 >= n) ? 0 : shadow_rp + 1;
                  rs.ok = 1'b1;
               end
            end
            OP_READ: begin
               if (int'(rq.peek) < entry_count(n)) begin
                  p = shadow_rp + int'(rq.peek);
                  if (p >= n) p -= n;
                  rs.data = shadow_slots[p] & lane_mask(eb);
                  rs.ok = 1'b1;
               end
            end
            default: begin
               shadow_wp = 0;
               shadow_rp = 0;
               rs.ok = 1'b1;
            end
         endcase
      end
      rs.count = 8'(entry_count(n));
      rs.empty = (shadow_wp == shadow_rp);
      rs.full  = ring_full(n);
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", field, got, want, $time);
      mismatch_count++;
   endtask

   task automatic check_result();
      fifo_result want;
      if (expected_responses.size() == 0) begin
         report_mismatch("unexpected response, data_out", rsp_data_out, 64'd0);
         return;
      end
      want = expected_responses.pop_front();
      if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
      if (rsp_data_out !== want.data) report_mismatch("data_out", rsp_data_out, want.data);
      if (rsp_stored_count !== want.count)
         report_mismatch("stored_count", rsp_stored_count, want.count);
      if (rsp_is_empty !== want.empty) report_mismatch("is_empty", rsp_is_empty, want.empty);
      if (rsp_is_full !== want.full) report_mismatch("is_full", rsp_is_full, want.full);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) check_result();
      if (hold_request) begin
         hold_left = 60;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_QUEUE_SIZE) shadow_qs = val[8:0];
      else if (idx == CSR_ELEMENT_BYTES) shadow_eb = val[3:0];
      shadow_wp = 0;
      shadow_rp = 0;
   endtask

   task automatic issue_request(input fifo_request rq, input bit typed,
                                input fifo_result typed_res);
      fifo_result predicted;
      int         eb;
      logic [7:0] need;
      eb = elem_len();
      // widen a partial push whose kept bytes were never stored
      if (rq.op == OP_PUSH && rq.count_bytes != 0 && int'(rq.count_bytes) < eb) begin
         need = byte_lanes(eb) & ~byte_lanes(int'(rq.count_bytes));
         if ((shadow_written[shadow_wp] & need) != need) rq.count_bytes = 4'd0;
      end
      apply_operation(rq, predicted);
      expected_responses.push_back(typed ? typed_res : predicted);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= rq.op;
      req_data_in    <= rq.data;
      req_byte_count <= rq.count_bytes;
      req_peek_index <= rq.peek;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   function automatic fifo_request random_request(bit filling);
      fifo_request rq;
      int          pick;
      int          held;
      pick = $urandom_range(0, 99);
      held = entry_count(ring_slots());
      if (pick < (filling ? 55 : 15)) rq.op = OP_PUSH;
      else if (pick < 65) rq.op = OP_POP;
      else if (pick < 97) rq.op = OP_READ;
      else rq.op = OP_CLEAR;
      rq.data        = {$urandom, $urandom};
      rq.count_bytes = 4'($urandom_range(0, 15));
      if (held == 0 || $urandom_range(0, 3) == 0) rq.peek = 8'($urandom_range(0, 255));
      else rq.peek = 8'($urandom_range(0, held - 1));
      return rq;
   endfunction

   function automatic plan_row op_row(op_type op, logic [63:0] data, logic [3:0] bc,
                                      logic [7:0] peek);
      plan_row r;
      r = '{default: '0};
      r.rq = {op, data, bc, peek};
      return r;
   endfunction

   function automatic plan_row chk_row(op_type op, logic [63:0] data, logic [3:0] bc,
                                       logic [7:0] peek, fifo_result res);
      plan_row r;
      r = op_row(op, data, bc, peek);
      r.typed = 1'b1;
      r.res = res;
      return r;
   endfunction

   function automatic plan_row reg_row(csr_index_type idx, logic [31:0] val);
      plan_row r;
      r = '{default: '0};
      r.is_reg = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_PUSH;
      req_data_in    = '0;
      req_byte_count = '0;
      req_peek_index = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_QUEUE_SIZE;
      csr_data       = '0;
      foreach (shadow_written[i]) begin
         shadow_written[i] = 8'h00;
         shadow_slots[i]   = '0;
      end
      shadow_wp = 0;
      shadow_rp = 0;
      shadow_qs = QUEUE_SIZE_RESET;
      shadow_eb = ELEMENT_BYTES_RESET;

      // ring not configured: everything fails
      plan.push_back(chk_row(OP_PUSH, ONES, 4'd0, 8'd0, UNINIT_FAIL));
      plan.push_back(chk_row(OP_POP, 64'd0, 4'd0, 8'd0, UNINIT_FAIL));
      plan.push_back(chk_row(OP_READ, 64'd0, 4'd0, 8'd0, UNINIT_FAIL));
      plan.push_back(chk_row(OP_CLEAR, 64'd0, 4'd0, 8'd0, UNINIT_FAIL));
      // single slot: empty and full at once
      plan.push_back(reg_row(CSR_QUEUE_SIZE, 32'd1));
      plan.push_back(chk_row(OP_PUSH, ONES, 4'd0, 8'd0, {1'b0, 64'd0, 8'd0, 1'b1, 1'b1}));
      plan.push_back(chk_row(OP_CLEAR, 64'd0, 4'd0, 8'd0, {1'b1, 64'd0, 8'd0, 1'b1, 1'b1}));
      // two slots: full, empty, wrap, partial push
      plan.push_back(reg_row(CSR_QUEUE_SIZE, 32'd2));
      plan.push_back(chk_row(OP_PUSH, ONES, 4'd0, 8'd0, {1'b1, 64'd0, 8'd1, 1'b0, 1'b1}));
      plan.push_back(chk_row(OP_PUSH, 64'h5555_5555_5555_5555, 4'd0, 8'd0,
                             {1'b0, 64'd0, 8'd1, 1'b0, 1'b1}));
      plan.push_back(chk_row(OP_POP, 64'd0, 4'd0, 8'd0, {1'b1, ONES, 8'd0, 1'b1, 1'b0}));
      plan.push_back(chk_row(OP_POP, 64'd0, 4'd0, 8'd0, {1'b0, 64'd0, 8'd0, 1'b1, 1'b0}));
      plan.push_back(op_row(OP_PUSH, 64'h0123_4567_89AB_CDEF, 4'd0, 8'd0));
      plan.push_back(op_row(OP_POP, 64'd0, 4'd0, 8'd0));
      plan.push_back(op_row(OP_PUSH, 64'd0, 4'd3, 8'd0));
      plan.push_back(op_row(OP_READ, 64'd0, 4'd0, 8'd0));
      plan.push_back(op_row(OP_READ, 64'd0, 4'd0, 8'd1));
      // largest ring, short elements
      plan.push_back(reg_row(CSR_QUEUE_SIZE, 32'd256));
      plan.push_back(reg_row(CSR_ELEMENT_BYTES, 32'd3));
      plan.push_back(op_row(OP_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 8'd0));
      plan.push_back(op_row(OP_PUSH, 64'h1122_3344_5566_7788, 4'd8, 8'd0));
      plan.push_back(op_row(OP_READ, 64'd0, 4'd0, 8'd255));
      plan.push_back(op_row(OP_READ, 64'd0, 4'd0, 8'd1));
      plan.push_back(op_row(OP_POP, 64'd0, 4'd0, 8'd0));
      plan.push_back(chk_row(OP_CLEAR, 64'd0, 4'd0, 8'd0, {1'b1, 64'd0, 8'd0, 1'b1, 1'b0}));
      // oversized ring and element, then zero-byte elements
      plan.push_back(reg_row(CSR_QUEUE_SIZE, 32'd511));
      plan.push_back(reg_row(CSR_ELEMENT_BYTES, 32'd15));
      plan.push_back(op_row(OP_PUSH, ONES, 4'd15, 8'd0));
      plan.push_back(op_row(OP_READ, 64'd0, 4'd0, 8'd0));
      plan.push_back(reg_row(CSR_ELEMENT_BYTES, 32'd0));
      plan.push_back(op_row(OP_PUSH, 64'h0123_4567_89AB_CDEF, 4'd0, 8'd0));
      plan.push_back(op_row(OP_POP, 64'd0, 4'd0, 8'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 19;
      rsp_idle_pct = 83;
      foreach (plan[i]) begin
         if (plan[i].is_reg) write_register(plan[i].reg_idx, plan[i].reg_val);
         else issue_request(plan[i].rq, plan[i].typed, plan[i].res);
      end

      for (int ph = 0; ph < 9; ph++) begin
         req_idle_pct = (ph < 3) ? 19 : ((ph < 6) ? 83 : 0);
         rsp_idle_pct = (ph < 3) ? 83 : ((ph < 6) ? 19 : 0);
         write_register(CSR_QUEUE_SIZE, phase_qs[ph]);
         write_register(CSR_ELEMENT_BYTES, phase_eb[ph]);
         for (int k = 0; k < 100; k++) begin
            if (ph == 6 && k == 30) hold_request = 1'b1;
            if (ph == 7 && k == 50) drain_results();
            issue_request(random_request(((k / 24) % 2) == 0), 1'b0, '0);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
src/rfip_pkg.sv
src/ring_fifo_with_indexed_peek.sv
verif/tb_ring_fifo_with_indexed_peek.sv
